// ----- design/rbscr_pkg.sv -----
// ============================================================================
// rbscr_pkg
// Shared types, constants and arithmetic helpers for the rigid body step.
// ============================================================================
package rbscr_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgIdxW = 3;

    localparam logic signed [31:0] SLOP_Q16 = 32'sd655;
    localparam logic signed [31:0] REST_THR_Q16 = 32'sd13107;
    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    localparam logic [31:0] GRAV_X_RST = 32'h0000_0000;
    localparam logic [31:0] GRAV_Y_RST = 32'hFFF6_3333;
    localparam logic [31:0] GRAV_Z_RST = 32'h0000_0000;
    localparam logic [4:0] MODE_RST = 5'd1;
    localparam logic [17:0] REST_RST = 18'd32768;
    localparam logic [30:0] RADIUS_RST = 31'd65536;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_COLL = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_NOP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_GX = 3'd0,
        CFG_GY = 3'd1,
        CFG_GZ = 3'd2,
        CFG_MODE = 3'd3,
        CFG_REST = 3'd4,
        CFG_RADIUS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] action;
        logic [15:0] dt;
        logic swept_hit;
        logic self_is_sphere;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] contact_z;
        logic signed [31:0] penetration;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } out_item_t;

    // Shared multiplier request: operands are 33-bit signed.
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } mul_req_t;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = I32_MAX;
        end else if (v < -34'sh0_8000_0000) begin
            r = I32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        return sat34(s);
    endfunction

endpackage

// ----- design/rigid_body_step_collision_response.sv -----
// ============================================================================
// rigid_body_step_collision_response
// Rigid body integrator and collision response in signed Q16.16.
// ============================================================================
// One beat in, one beat out. The body state (sphere center position and
// velocity) lives here; a tick integrates it with gravity, a collision item
// repositions and reflects it, a load item overwrites it. All products go
// through one registered 33x33 multiplier driven by a small sequencer, so each
// product is issued, registered, then used. After the accepting cycle a tick
// works axis by axis (gravity product when enabled, then position product; a
// frozen axis only has its velocity zeroed), a collision runs as needed the radius
// product, three placement products, three dot products, the restitution
// product and three velocity products, and a load, a kinematic item or the
// unused action does no work. The result beat is then offered until taken.
// The block is not ready while an item is in work or a result waits.
module rigid_body_step_collision_response (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rbscr_pkg::in_item_t    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rbscr_pkg::out_item_t   m_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_idx,
    input  logic [31:0]            cfg_data
);
    import rbscr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GV, ST_VP, ST_RAD, ST_POS, ST_DOT, ST_REST, ST_VEL, ST_OUT
    } state_t;

    // configuration
    logic signed [31:0] grav_reg [3];
    logic [4:0]  mode_reg;
    logic [17:0] rest_reg;
    logic [30:0] radius_reg;

    // body state
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];

    state_t      state_reg;
    logic [1:0]  axis_reg;     // axis in work
    logic        phase_reg;    // 0 issue, 1 product ready
    in_item_t    item_reg;
    logic signed [31:0] dist_reg;  // distance or delta multiplier operand
    logic signed [31:0] vn_reg;
    logic signed [33:0] dot_reg;   // unsaturated partial dot product
    logic        place_reg;    // swept placement vs push-out

    mul_req_t    req;
    logic signed [31:0] prod;
    logic signed [31:0] nrm [3];
    logic signed [31:0] cnt [3];
    logic frz;
    logic kin;

    assign nrm[0] = item_reg.normal_x;
    assign nrm[1] = item_reg.normal_y;
    assign nrm[2] = item_reg.normal_z;
    assign cnt[0] = item_reg.contact_x;
    assign cnt[1] = item_reg.contact_y;
    assign cnt[2] = item_reg.contact_z;
    assign frz = mode_reg[3'd2 + 3'(axis_reg)];
    assign kin = mode_reg[1];

    rbscr_mul u_mul (.aclk(aclk), .req(req), .prod_reg(prod));

    // Operand select for the shared multiplier.
    always_comb begin
        req.a = '0;
        req.b = '0;
        case (state_reg)
            ST_GV: begin
                req.a = 33'(grav_reg[axis_reg]);
                req.b = 33'({1'b0, item_reg.dt});
            end
            ST_VP: begin
                req.a = 33'(vel_reg[axis_reg]);
                req.b = 33'({1'b0, item_reg.dt});
            end
            ST_RAD: begin
                req.a = 33'({1'b0, radius_reg});
                req.b = 33'(SLOP_Q16);
            end
            ST_POS, ST_VEL: begin
                req.a = 33'(nrm[axis_reg]);
                req.b = 33'(dist_reg);
            end
            ST_DOT: begin
                req.a = 33'(vel_reg[axis_reg]);
                req.b = 33'(nrm[axis_reg]);
            end
            ST_REST: begin
                req.a = -33'(vn_reg);
                req.b = 33'({1'b0, rest_reg});
            end
            default: begin
                req.a = '0;
                req.b = '0;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data.pos_x = pos_reg[0];
    assign m_data.pos_y = pos_reg[1];
    assign m_data.pos_z = pos_reg[2];
    assign m_data.vel_x = vel_reg[0];
    assign m_data.vel_y = vel_reg[1];
    assign m_data.vel_z = vel_reg[2];

    logic signed [32:0] rad_sum;
    logic signed [31:0] nv;
    logic signed [32:0] delta;
    logic signed [33:0] dot_sum;
    assign rad_sum = 33'({1'b0, radius_reg}) + 33'(prod);
    assign nv = (prod < REST_THR_Q16) ? 32'sd0 : prod;
    assign delta = 33'(nv) - 33'(vn_reg);
    // three products summed exactly, saturated once at the end
    assign dot_sum = dot_reg + 34'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg <= '0;
            phase_reg <= 1'b0;
            grav_reg[0] <= GRAV_X_RST;
            grav_reg[1] <= GRAV_Y_RST;
            grav_reg[2] <= GRAV_Z_RST;
            mode_reg <= MODE_RST;
            rest_reg <= REST_RST;
            radius_reg <= RADIUS_RST;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_GX: grav_reg[0] <= cfg_data;
                    CFG_GY: grav_reg[1] <= cfg_data;
                    CFG_GZ: grav_reg[2] <= cfg_data;
                    CFG_MODE: mode_reg <= cfg_data[4:0];
                    CFG_REST: rest_reg <= cfg_data[17:0];
                    CFG_RADIUS: radius_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        axis_reg <= '0;
                        phase_reg <= 1'b0;
                        vn_reg <= '0;
                        dot_reg <= '0;
                        if (s_data.action == ACT_LOAD) begin
                            pos_reg[0] <= s_data.normal_x;
                            pos_reg[1] <= s_data.normal_y;
                            pos_reg[2] <= s_data.normal_z;
                            vel_reg[0] <= s_data.contact_x;
                            vel_reg[1] <= s_data.contact_y;
                            vel_reg[2] <= s_data.contact_z;
                            state_reg <= ST_OUT;
                        end else if (kin || s_data.action == ACT_NOP) begin
                            state_reg <= ST_OUT;
                        end else if (s_data.action == ACT_TICK) begin
                            state_reg <= ST_GV;
                        end else if (s_data.swept_hit) begin
                            place_reg <= 1'b1;
                            state_reg <= s_data.self_is_sphere ? ST_RAD : ST_DOT;
                        end else if (s_data.penetration > 0) begin
                            place_reg <= 1'b0;
                            dist_reg <= s_data.penetration;
                            state_reg <= ST_POS;
                        end else begin
                            state_reg <= ST_DOT;
                        end
                    end
                end
                ST_GV: begin
                    // gravity term for one axis; frozen axes zero velocity
                    if (frz) begin
                        vel_reg[axis_reg] <= '0;
                        if (axis_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end else if (!mode_reg[0]) begin
                        state_reg <= ST_VP;
                    end else if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        vel_reg[axis_reg] <= add_sat(vel_reg[axis_reg], prod);
                        state_reg <= ST_VP;
                    end
                end
                ST_VP: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        pos_reg[axis_reg] <= add_sat(pos_reg[axis_reg], prod);
                        if (axis_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg <= axis_reg + 2'd1;
                            state_reg <= ST_GV;
                        end
                    end
                end
                ST_RAD: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        // sum is never negative; bit 31 set means past the max
                        dist_reg <= (rad_sum[32] || rad_sum[31]) ? I32_MAX
                                                                 : rad_sum[31:0];
                        state_reg <= ST_POS;
                    end
                end
                ST_POS: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        pos_reg[axis_reg] <= add_sat(
                            place_reg ? cnt[axis_reg] : pos_reg[axis_reg], prod);
                        if (axis_reg == 2'd2) begin
                            axis_reg <= '0;
                            state_reg <= ST_DOT;
                        end else begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                end
                ST_DOT: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        if (axis_reg == 2'd2) begin
                            vn_reg <= sat34(dot_sum);
                            axis_reg <= '0;
                            state_reg <= (sat34(dot_sum) < 0) ? ST_REST : ST_OUT;
                        end else begin
                            dot_reg <= dot_sum;
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                end
                ST_REST: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        // delta is positive here since vn < 0
                        dist_reg <= delta[32] || delta[31] ? I32_MAX : delta[31:0];
                        state_reg <= ST_VEL;
                    end
                end
                ST_VEL: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        vel_reg[axis_reg] <= add_sat(vel_reg[axis_reg], prod);
                        if (axis_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Never ready while a result is pending.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready with result pending");
    // An accepted item is followed by not-ready.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready after accept");
    // Result holds while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed under stall");
endmodule

// ----- design/rbscr_mul.sv -----
// ============================================================================
// rbscr_mul
// Registered Q16.16 multiplier: floor shift by 16, saturated to 32 bits.
// ============================================================================
module rbscr_mul (
    input  logic                 aclk,
    input  rbscr_pkg::mul_req_t  req,
    output logic signed [31:0]   prod_reg
);
    import rbscr_pkg::*;

    logic signed [65:0] full;
    logic signed [49:0] shifted;
    logic signed [31:0] prod_next;

    always_comb begin
        full = 66'(req.a) * 66'(req.b);
        shifted = full[65:16];  // arithmetic shift floors
        if (shifted > 50'sh7FFF_FFFF) begin
            prod_next = I32_MAX;
        end else if (shifted < -50'sh8000_0000) begin
            prod_next = I32_MIN;
        end else begin
            prod_next = shifted[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end
endmodule
